@@ sv/rhc_pkg.sv @@
// Shared constants for the RGB to HSV converter.
package rhc_pkg;

   localparam int unsigned CHANNEL_BITS_DEFAULT  = 8;
   localparam int unsigned FRACTION_BITS_DEFAULT = 16;

   // Entries in the queue between classification and division; a power of two.
   localparam int unsigned QUEUE_DEPTH = 2;

endpackage

@@ sv/rgb_to_hsv_converter_top.sv @@
// Top level of the RGB to HSV converter.
//
// One pixel word in on the req_ stream, one HSV word out on the rsp_ stream,
// in order, one result per pixel. A pixel is taken when req_tvalid and
// req_tready are both high; a result is handed over when rsp_tvalid and
// rsp_tready are both high.
// Throughput is one pixel per clock while the receiver keeps taking results.
// The hue and saturation quotients come out of a divider pipeline with one
// stage per fraction bit, fed from a two-word queue behind the classification
// logic.
// When the receiver stalls, the result at the output holds and the divider
// pipeline freezes; the queue still takes pixels until it is full, and then
// req_tready drops. req_tready does not depend on rsp_tready in the same
// cycle. Reset empties the queue and the pipeline; no results are pending
// after it, and the block is ready in the first cycle after reset.
module rgb_to_hsv_converter_top #(
   parameter int unsigned CHANNEL_BITS  = rhc_pkg::CHANNEL_BITS_DEFAULT,
   parameter int unsigned FRACTION_BITS = rhc_pkg::FRACTION_BITS_DEFAULT,
   localparam int unsigned REQ_BITS     = ((3*CHANNEL_BITS + 7) / 8) * 8,
   localparam int unsigned RSP_BITS     = ((2*FRACTION_BITS + CHANNEL_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_BITS-1:0] req_tdata,  // red_in, green_in, blue_in, zero fill
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata   // hue_out, saturation_out, value_out, zero fill
);

   localparam int unsigned ENTRY_BITS = 4*CHANNEL_BITS + 8;

   logic [ENTRY_BITS-1:0]    push_entry;
   logic [ENTRY_BITS-1:0]    head_entry;
   logic                     head_valid;
   logic                     pop;
   logic [FRACTION_BITS-1:0] hue;
   logic [FRACTION_BITS-1:0] saturation;
   logic [CHANNEL_BITS-1:0]  value;

   rhc_front #(
      .CHANNEL_BITS(CHANNEL_BITS)
   ) u_front (
      .red   (req_tdata[CHANNEL_BITS-1:0]),
      .green (req_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS]),
      .blue  (req_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS]),
      .entry (push_entry)
   );

   rhc_queue #(
      .ENTRY_BITS(ENTRY_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_entry (push_entry),
      .head_valid (head_valid),
      .pop        (pop),
      .head_entry (head_entry)
   );

   rhc_divider #(
      .CHANNEL_BITS  (CHANNEL_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .hue        (hue),
      .saturation (saturation),
      .value      (value)
   );

   assign rsp_tdata = RSP_BITS'({value, saturation, hue});

endmodule

@@ sv/rhc_front.sv @@
// Front end: finds max, min and chroma of a pixel and sets up both divisions.
module rhc_front #(
   parameter int unsigned CHANNEL_BITS  = rhc_pkg::CHANNEL_BITS_DEFAULT,
   localparam int unsigned HUE_BITS     = CHANNEL_BITS + 3
) (
   input  logic [CHANNEL_BITS-1:0] red,
   input  logic [CHANNEL_BITS-1:0] green,
   input  logic [CHANNEL_BITS-1:0] blue,
   output logic [4*CHANNEL_BITS+8-1:0] entry
);

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] value;
      logic [HUE_BITS-1:0]     hue_num;
      logic [HUE_BITS-1:0]     hue_div;
      logic [CHANNEL_BITS-1:0] sat_num;
      logic                    gray;
      logic                    sat_full;
   } entry_type;

   logic [CHANNEL_BITS-1:0] hi;
   logic [CHANNEL_BITS-1:0] lo;
   logic [CHANNEL_BITS-1:0] chroma;
   logic [HUE_BITS-1:0]     chroma_x;
   logic [HUE_BITS-1:0]     red_x;
   logic [HUE_BITS-1:0]     green_x;
   logic [HUE_BITS-1:0]     blue_x;
   logic [HUE_BITS-1:0]     six_chroma;
   logic [HUE_BITS-1:0]     num;
   entry_type               result;

   always_comb begin
      hi = red;
      if (green > hi) hi = green;
      if (blue > hi) hi = blue;
      lo = red;
      if (green < lo) lo = green;
      if (blue < lo) lo = blue;
   end

   assign chroma     = hi - lo;
   assign chroma_x   = HUE_BITS'(chroma);
   assign red_x      = HUE_BITS'(red);
   assign green_x    = HUE_BITS'(green);
   assign blue_x     = HUE_BITS'(blue);
   assign six_chroma = (chroma_x << 2) + (chroma_x << 1);

   // Red wins ties over green, green over blue. The red sector wraps a
   // negative offset into the last sixth of the turn.
   always_comb begin
      priority if (red == hi) begin
         if (green >= blue) num = green_x - blue_x;
         else num = six_chroma - (blue_x - green_x);
      end else if (green == hi) begin
         num = (chroma_x << 1) + blue_x - red_x;
      end else begin
         num = (chroma_x << 2) + red_x - green_x;
      end
   end

   always_comb begin
      result.value    = hi;
      result.hue_num  = num;
      result.hue_div  = six_chroma;
      result.gray     = (chroma == '0);
      // Chroma equals the maximum exactly when the minimum is zero.
      result.sat_full = (lo == '0) && (chroma != '0);
      result.sat_num  = result.sat_full ? '0 : chroma;
   end

   assign entry = result;

endmodule

@@ sv/rhc_queue.sv @@
// Short queue that decouples the front end from the divider pipeline.
module rhc_queue #(
   parameter int unsigned ENTRY_BITS = 40,
   localparam int unsigned DEPTH     = rhc_pkg::QUEUE_DEPTH,
   localparam int unsigned PTR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  logic [ENTRY_BITS-1:0] push_entry,
   output logic                  head_valid,
   input  logic                  pop,
   output logic [ENTRY_BITS-1:0] head_entry
);

   logic [ENTRY_BITS-1:0] slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]     count_ff, count_in;
   logic                  push;
   logic                  take;

   assign push_ready = (count_ff < (PTR_BITS+1)'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign take       = pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? PTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = take ? PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !take) count_in = count_ff + 1'b1;
      else if (take && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_BITS+1)'(DEPTH))
      else $error("queue holds more words than its depth");

   a_take_nonempty: assert property (@(posedge clock) disable iff (reset)
      take |=> (count_ff == $past(count_ff) - 1'b1) || $past(push))
      else $error("queue count did not drop after a pop");
`endif

endmodule

@@ sv/rhc_divider.sv @@
// Back end: pipelined restoring dividers for hue and saturation, one bit per stage.
module rhc_divider #(
   parameter int unsigned CHANNEL_BITS  = rhc_pkg::CHANNEL_BITS_DEFAULT,
   parameter int unsigned FRACTION_BITS = rhc_pkg::FRACTION_BITS_DEFAULT,
   localparam int unsigned HUE_BITS     = CHANNEL_BITS + 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  logic [4*CHANNEL_BITS+8-1:0] head_entry,
   output logic                      pop,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [FRACTION_BITS-1:0]  hue,
   output logic [FRACTION_BITS-1:0]  saturation,
   output logic [CHANNEL_BITS-1:0]   value
);

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] value;
      logic [HUE_BITS-1:0]     hue_num;
      logic [HUE_BITS-1:0]     hue_div;
      logic [CHANNEL_BITS-1:0] sat_num;
      logic                    gray;
      logic                    sat_full;
   } entry_type;

   typedef struct packed {
      logic [HUE_BITS-1:0]      hue_rem;
      logic [HUE_BITS-1:0]      hue_div;
      logic [FRACTION_BITS-1:0] hue_quo;
      logic [CHANNEL_BITS-1:0]  sat_rem;
      logic [CHANNEL_BITS-1:0]  sat_div;
      logic [FRACTION_BITS-1:0] sat_quo;
      logic [CHANNEL_BITS-1:0]  value;
      logic                     gray;
      logic                     sat_full;
   } stage_type;

   entry_type head;
   stage_type first;
   stage_type src_w    [FRACTION_BITS];
   logic      src_valid[FRACTION_BITS];
   stage_type stage_in [FRACTION_BITS];
   stage_type stage_ff [FRACTION_BITS];
   logic      valid_ff [FRACTION_BITS];
   logic      advance;
   stage_type last;

   assign head    = head_entry;
   assign last    = stage_ff[FRACTION_BITS-1];
   // The whole pipeline moves unless a finished word is waiting at the output.
   assign advance = !valid_ff[FRACTION_BITS-1] || out_ready;
   assign pop     = advance;

   always_comb begin
      first.hue_rem  = head.hue_num;
      first.hue_div  = head.hue_div;
      first.hue_quo  = '0;
      first.sat_rem  = head.sat_num;
      first.sat_div  = head.value;
      first.sat_quo  = '0;
      first.value    = head.value;
      first.gray     = head.gray;
      first.sat_full = head.sat_full;
   end

   assign src_w[0]     = first;
   assign src_valid[0] = head_valid;
   for (genvar k = 1; k < FRACTION_BITS; k++) begin : g_src
      assign src_w[k]     = stage_ff[k-1];
      assign src_valid[k] = valid_ff[k-1];
   end

   // Each stage shifts the remainder left and subtracts the divisor if it fits.
   always_comb begin
      logic [HUE_BITS:0]     hue_sh;
      logic [CHANNEL_BITS:0] sat_sh;
      logic                  hue_ge;
      logic                  sat_ge;
      for (int k = 0; k < FRACTION_BITS; k++) begin
         hue_sh = {src_w[k].hue_rem, 1'b0};
         sat_sh = {src_w[k].sat_rem, 1'b0};
         hue_ge = hue_sh >= {1'b0, src_w[k].hue_div};
         sat_ge = sat_sh >= {1'b0, src_w[k].sat_div};
         stage_in[k] = src_w[k];
         stage_in[k].hue_rem = hue_ge ? HUE_BITS'(hue_sh - {1'b0, src_w[k].hue_div})
                                      : hue_sh[HUE_BITS-1:0];
         stage_in[k].sat_rem = sat_ge ? CHANNEL_BITS'(sat_sh - {1'b0, src_w[k].sat_div})
                                      : sat_sh[CHANNEL_BITS-1:0];
         stage_in[k].hue_quo = {src_w[k].hue_quo[FRACTION_BITS-2:0], hue_ge};
         stage_in[k].sat_quo = {src_w[k].sat_quo[FRACTION_BITS-2:0], sat_ge};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < FRACTION_BITS; k++) begin
         if (reset) valid_ff[k] <= 1'b0;
         else if (advance) valid_ff[k] <= src_valid[k];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < FRACTION_BITS; k++) stage_ff[k] <= stage_in[k];
      end
   end

   assign out_valid  = valid_ff[FRACTION_BITS-1];
   assign value      = last.value;
   assign hue        = last.gray ? '0 : last.hue_quo;
   assign saturation = last.gray ? '0 : (last.sat_full ? '1 : last.sat_quo);

`ifndef NO_ASSERTIONS
   a_hue_rem: assert property (@(posedge clock) disable iff (reset)
      out_valid && !last.gray |-> last.hue_rem < last.hue_div)
      else $error("hue remainder not below its divisor");

   a_sat_rem: assert property (@(posedge clock) disable iff (reset)
      out_valid && !last.gray && !last.sat_full |-> last.sat_rem < last.sat_div)
      else $error("saturation remainder not below its divisor");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(last))
      else $error("stalled result changed in the divider");
`endif

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the RGB to HSV converter: directed pixels, then random traffic.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned CHAN_BITS   = rhc_pkg::CHANNEL_BITS_DEFAULT;
   localparam int unsigned FRAC_BITS   = rhc_pkg::FRACTION_BITS_DEFAULT;
   localparam int unsigned RANDOM_PIXELS = 1030;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam logic [63:0] FRAC_MAX    = (64'd1 << FRAC_BITS) - 1;

   // Pixel word, red in the lowest bits.
   typedef struct packed {
      logic [CHAN_BITS-1:0] blue;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] red;
   } pixel_type;

   // Result word, hue in the lowest bits.
   typedef struct packed {
      logic [CHAN_BITS-1:0] value;
      logic [FRAC_BITS-1:0] saturation;
      logic [FRAC_BITS-1:0] hue;
   } hsv_type;

   typedef struct {
      pixel_type px;
      bit        known;
      hsv_type   want;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [23:0]  req_tdata = '0;   // red_in, green_in, blue_in
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;        // hue_out, saturation_out, value_out

   hsv_type      expected_hsv[$];
   stim_row_type directed_rows[$];
   int           hsv_errors = 0;
   int           results_seen = 0;
   int           hold_left = 0;
   int           stall_cycles = 0;
   bit           calm = 1'b0;

   rgb_to_hsv_converter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic hsv_type predict_hsv(input pixel_type px);
      logic [63:0] r, g, b, hi, lo, chroma, num, hue, sat;
      hsv_type     res;
      r = px.red;
      g = px.green;
      b = px.blue;
      hi = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      lo = r;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      chroma = hi - lo;
      hue = 0;
      sat = 0;
      if (chroma != 0) begin
         // Red wins ties, then green; a negative red-sector offset wraps by a full turn.
         if (r == hi) begin
            num = (g >= b) ? g - b : 6 * chroma - (b - g);
         end else if (g == hi) begin
            num = 2 * chroma + b - r;
         end else begin
            num = 4 * chroma + r - g;
         end
         hue = (num << FRAC_BITS) / (6 * chroma);
         if (hue > FRAC_MAX) hue = FRAC_MAX;
         sat = (chroma << FRAC_BITS) / hi;
         if (sat > FRAC_MAX) sat = FRAC_MAX;
      end
      res.hue = hue[FRAC_BITS-1:0];
      res.saturation = sat[FRAC_BITS-1:0];
      res.value = hi[CHAN_BITS-1:0];
      return res;
   endfunction

   function automatic stim_row_type stim_row(input int r, input int g, input int b,
                                             input bit known = 1'b0, input int h = 0,
                                             input int s = 0, input int v = 0);
      stim_row_type row_out;
      row_out.px = '{blue: CHAN_BITS'(b), green: CHAN_BITS'(g), red: CHAN_BITS'(r)};
      row_out.known = known;
      row_out.want = '{value: CHAN_BITS'(v), saturation: FRAC_BITS'(s),
                       hue: FRAC_BITS'(h)};
      return row_out;
   endfunction

   task automatic send_pixel(input pixel_type px, input hsv_type want);
      req_tdata <= px;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_hsv.push_back(want);
   endtask

   task automatic sender_gap();
      while (!calm && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Result side: random back-pressure, one long hold-off, and the field checks.
   initial begin
      hsv_type got;
      hsv_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = hsv_type'(rsp_tdata);
            if (expected_hsv.size() == 0) begin
               $display("%0t: result word with nothing expected: %h", $realtime, rsp_tdata);
               hsv_errors++;
            end else begin
               want = expected_hsv.pop_front();
               if (got.hue !== want.hue) begin
                  $display("%0t: hue expected %0d actual %0d", $realtime, want.hue, got.hue);
                  hsv_errors++;
               end
               if (got.saturation !== want.saturation) begin
                  $display("%0t: saturation expected %0d actual %0d", $realtime,
                           want.saturation, got.saturation);
                  hsv_errors++;
               end
               if (got.value !== want.value) begin
                  $display("%0t: value expected %0d actual %0d", $realtime,
                           want.value, got.value);
                  hsv_errors++;
               end
            end
            results_seen++;
            // Hold off long enough that the queue fills and the input stalls.
            if (results_seen == 150) hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 17);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      pixel_type px;
      int        kind;
      int        base;
      int        chan [3];

      // Gray, pure primaries and the smallest chroma have results readable by eye.
      directed_rows.push_back(stim_row(0, 0, 0, 1, 0, 0, 0));
      directed_rows.push_back(stim_row(255, 255, 255, 1, 0, 0, 255));
      directed_rows.push_back(stim_row(128, 128, 128, 1, 0, 0, 128));
      directed_rows.push_back(stim_row(1, 1, 1, 1, 0, 0, 1));
      directed_rows.push_back(stim_row(255, 0, 0, 1, 0, 65535, 255));
      directed_rows.push_back(stim_row(0, 255, 0, 1, 21845, 65535, 255));
      directed_rows.push_back(stim_row(0, 0, 255, 1, 43690, 65535, 255));
      directed_rows.push_back(stim_row(1, 0, 0, 1, 0, 65535, 1));
      // Red sector with blue above green wraps into the last sector.
      directed_rows.push_back(stim_row(255, 0, 1));
      directed_rows.push_back(stim_row(255, 254, 255));
      directed_rows.push_back(stim_row(200, 0, 200));
      // Ties for the maximum, then pixels with a single largest channel.
      directed_rows.push_back(stim_row(200, 200, 0));
      directed_rows.push_back(stim_row(0, 200, 200));
      directed_rows.push_back(stim_row(255, 255, 0));
      directed_rows.push_back(stim_row(0, 255, 255));
      directed_rows.push_back(stim_row(255, 0, 255));
      directed_rows.push_back(stim_row(170, 85, 255));
      directed_rows.push_back(stim_row(85, 170, 255));
      directed_rows.push_back(stim_row(255, 128, 128));
      directed_rows.push_back(stim_row(10, 240, 20));
      directed_rows.push_back(stim_row(8'h55, 8'hAA, 8'h0F));
      directed_rows.push_back(stim_row(8'hAA, 8'h55, 8'hF0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         sender_gap();
         send_pixel(directed_rows[i].px, directed_rows[i].known ?
                    directed_rows[i].want : predict_hsv(directed_rows[i].px));
      end

      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         calm = (n >= 300 && n < 500);
         if (n == 700) begin
            // Let the pipeline drain completely before going on.
            req_tvalid <= 1'b0;
            do @(posedge clock); while (expected_hsv.size() != 0);
         end
         kind = $urandom_range(9);
         base = $urandom_range(255);
         for (int c = 0; c < 3; c++) begin
            case (kind)
               4: begin
                  chan[c] = base;
               end
               5: begin
                  chan[c] = $urandom_range(1) ? 255 : 0;
               end
               6: begin
                  chan[c] = $urandom_range(base);
               end
               7: begin
                  chan[c] = base + $urandom_range(2) - 1;
                  if (chan[c] < 0) chan[c] = 0;
                  if (chan[c] > 255) chan[c] = 255;
               end
               default: begin
                  chan[c] = $urandom_range(255);
               end
            endcase
         end
         // Two channels share one value between 191 and 255.
         if (kind == 6) begin
            base = $urandom_range(2);
            chan[base] = 255 - $urandom_range(64);
            chan[(base + 1) % 3] = chan[base];
         end
         // One channel is set to a value between 223 and 255.
         if (kind >= 8) chan[$urandom_range(2)] = 255 - $urandom_range(32);
         px = '{blue: CHAN_BITS'(chan[2]), green: CHAN_BITS'(chan[1]),
                red: CHAN_BITS'(chan[0])};
         sender_gap();
         send_pixel(px, predict_hsv(px));
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      while (expected_hsv.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (hsv_errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
